// ===== rtl/core/tlik_pkg.sv =====
`default_nettype none
package tlik_pkg;

	typedef struct packed {
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic [14:0]        inner_length;
		logic [14:0]        outer_length;
	} cmd_t;

	typedef struct packed {
		logic        reachable;
		logic [14:0] shoulder_angle;
		logic [14:0] elbow_angle;
	} res_t;

	localparam int SQRT_STEPS = 32;
	localparam int NORM_CELLS = 6;
	localparam int CW = 52;
	localparam int ZW = 33;

	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic [35:0]        PI_Q13      = 36'd25736;

	// how an atan ratio is resolved
	localparam logic [1:0] RAT_CORDIC = 2'd0;
	localparam logic [1:0] RAT_POS    = 2'd1;
	localparam logic [1:0] RAT_NEG    = 2'd2;
	localparam logic [1:0] RAT_ZERO   = 2'd3;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] root;
	} sq_t;

	typedef struct packed {
		logic [47:0] x;
		logic [47:0] my;
		logic        neg;
		logic        zero;
	} nrm_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cor_t;

	function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
		logic [ZW-1:0] v;
		case (i)
			5'd0:  v = 33'h03243F6A8;
			5'd1:  v = 33'h01DAC6705;
			5'd2:  v = 33'h00FADBAFC;
			5'd3:  v = 33'h007F56EA6;
			5'd4:  v = 33'h003FEAB76;
			5'd5:  v = 33'h001FFD55B;
			5'd6:  v = 33'h000FFFAAA;
			5'd7:  v = 33'h0007FFF55;
			5'd8:  v = 33'h0003FFFEA;
			5'd9:  v = 33'h0001FFFFD;
			5'd10: v = 33'h0000FFFFF;
			5'd11: v = 33'h00007FFFF;
			5'd12: v = 33'h00003FFFF;
			5'd13: v = 33'h00001FFFF;
			5'd14: v = 33'h00000FFFF;
			5'd15: v = 33'h000007FFF;
			5'd16: v = 33'h000003FFF;
			5'd17: v = 33'h000001FFF;
			5'd18: v = 33'h000000FFF;
			5'd19: v = 33'h0000007FF;
			5'd20: v = 33'h0000003FF;
			5'd21: v = 33'h0000001FF;
			5'd22: v = 33'h0000000FF;
			5'd23: v = 33'h00000007F;
			5'd24: v = 33'h00000003F;
			5'd25: v = 33'h00000001F;
			5'd26: v = 33'h00000000F;
			5'd27: v = 33'h000000008;
			5'd28: v = 33'h000000004;
			5'd29: v = 33'h000000002;
			5'd30: v = 33'h000000001;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [35:0] rat_val(input logic [1:0] code,
		input logic signed [ZW-1:0] z);
		logic signed [35:0] v;
		case (code)
			RAT_POS:  v = HALF_PI_Q30;
			RAT_NEG:  v = -HALF_PI_Q30;
			RAT_ZERO: v = '0;
			default:  v = 36'(z);
		endcase
		return v;
	endfunction

	function automatic logic [14:0] to_q13(input logic signed [35:0] z);
		logic signed [35:0] c;
		logic [35:0]        r;
		c = z;
		if (z < 0) c = '0;
		else if (z > PI_Q30) c = PI_Q30;
		r = (unsigned'(c) + 36'd65536) >> 17;
		if (r > PI_Q13) r = PI_Q13;
		return r[14:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tlik_stream_if.sv =====
`default_nettype none
interface tlik_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/two_link_inverse_kinematics_top.sv =====
`default_nettype none
// Channel  Dir  Payload                                             Beat when
// cmd      in   target_x, target_y, inner_length, outer_length      valid & ready
// res      out  reachable, shoulder_angle, elbow_angle              valid & ready
//
// One beat per cycle while the output is not stalled; the path runs through
// the 32-cell square-root chain and three parallel CORDIC chains.
// Reset clears only the valid bits of the pipeline.
// The whole pipeline holds while a result sits in the output register untaken.
module two_link_inverse_kinematics_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	tlik_stream_if.sink        cmd,
	tlik_stream_if.source      res
);
	import tlik_pkg::*;

	localparam int NSTEPS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
	localparam int CL     = 1 + NORM_CELLS + NSTEPS;
	localparam int LAT    = 5 + SQRT_STEPS + 1 + CL + 2;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        a2;
		logic signed [32:0] num;
		logic signed [49:0] e;
		logic               reach;
	} fr_t;

	typedef struct packed {
		logic       reach;
		logic       num_neg;
		logic [1:0] t_code;
		logic [1:0] k_code;
	} side_t;

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en        = !vld_q[LAT-1] || res.ready;
	assign cmd.ready = en;
	assign res.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], cmd.valid};
		end
	end

	// stage 1: squares and link product
	logic signed [15:0] x_s1, y_s1;
	logic [14:0]        a1_s1, a2_s1;
	logic [31:0]        xx_s1, yy_s1;
	logic [29:0]        aa1_s1, aa2_s1, a12_s1;
	logic signed [31:0] xx_w, yy_w;

	assign xx_w = 32'(cmd.data.target_x) * 32'(cmd.data.target_x);
	assign yy_w = 32'(cmd.data.target_y) * 32'(cmd.data.target_y);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= cmd.data.target_x;
			y_s1   <= cmd.data.target_y;
			a1_s1  <= cmd.data.inner_length;
			a2_s1  <= cmd.data.outer_length;
			xx_s1  <= unsigned'(xx_w);
			yy_s1  <= unsigned'(yy_w);
			aa1_s1 <= 30'(cmd.data.inner_length) * 30'(cmd.data.inner_length);
			aa2_s1 <= 30'(cmd.data.outer_length) * 30'(cmd.data.outer_length);
			a12_s1 <= 30'(cmd.data.inner_length) * 30'(cmd.data.outer_length);
		end
	end

	// stage 2: reach test on exact squares
	logic signed [15:0] x_s2, y_s2;
	logic [14:0]        a1_s2, a2_s2;
	logic signed [32:0] num_s2;
	logic [30:0]        den_s2;
	logic               reach_s2;
	logic [31:0]        r2_w, sum2_w, dif2_w, aa_w;

	assign r2_w   = xx_s1 + yy_s1;
	assign aa_w   = 32'(aa1_s1) + 32'(aa2_s1);
	assign sum2_w = aa_w + {1'b0, a12_s1, 1'b0};
	assign dif2_w = aa_w - {1'b0, a12_s1, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			a1_s2    <= a1_s1;
			a2_s2    <= a2_s1;
			den_s2   <= {a12_s1, 1'b0};
			num_s2   <= $signed({1'b0, r2_w}) - $signed({1'b0, aa_w});
			reach_s2 <= (a1_s1 != '0) && (a2_s1 != '0) &&
				(r2_w <= sum2_w) && (r2_w >= dif2_w);
		end
	end

	// stage 3: den -/+ num, shoulder denominator products
	logic signed [15:0] x_s3, y_s3;
	logic [14:0]        a2_s3;
	logic signed [32:0] num_s3;
	logic               reach_s3;
	logic [32:0]        p_s3, q_s3;
	logic [45:0]        a1den_s3;
	logic signed [48:0] a2num_s3;
	logic signed [33:0] p_w, q_w;
	logic [45:0]        a1den_w;
	logic signed [48:0] a2num_w;

	assign p_w     = $signed({3'b0, den_s2}) - 34'(num_s2);
	assign q_w     = $signed({3'b0, den_s2}) + 34'(num_s2);
	assign a1den_w = 46'(a1_s2) * 46'(den_s2);
	assign a2num_w = 49'($signed({1'b0, a2_s2})) * 49'(num_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			a2_s3    <= a2_s2;
			num_s3   <= num_s2;
			reach_s3 <= reach_s2;
			p_s3     <= p_w[32:0];
			q_s3     <= q_w[32:0];
			a1den_s3 <= a1den_w;
			a2num_s3 <= a2num_w;
		end
	end

	// stage 4: radicand partial products, shoulder denominator sum
	logic signed [15:0] x_s4, y_s4;
	logic [14:0]        a2_s4;
	logic signed [32:0] num_s4;
	logic               reach_s4;
	logic [49:0]        pl_s4;
	logic [48:0]        ph_s4;
	logic signed [49:0] e_s4;
	logic [49:0]        pl_w;
	logic [48:0]        ph_w;

	assign pl_w = 50'(p_s3) * 50'(q_s3[16:0]);
	assign ph_w = 49'(p_s3) * 49'(q_s3[32:17]);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4     <= x_s3;
			y_s4     <= y_s3;
			a2_s4    <= a2_s3;
			num_s4   <= num_s3;
			reach_s4 <= reach_s3;
			pl_s4    <= pl_w;
			ph_s4    <= ph_w;
			e_s4     <= $signed({4'b0, a1den_s3}) + 50'(a2num_s3);
		end
	end

	// stage 5: radicand
	fr_t         fr_s5;
	logic [63:0] v_s5;
	logic [65:0] v_w;

	assign v_w = 66'(pl_s4) + {ph_s4, 17'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			v_s5        <= v_w[63:0];
			fr_s5.x     <= x_s4;
			fr_s5.y     <= y_s4;
			fr_s5.a2    <= a2_s4;
			fr_s5.num   <= num_s4;
			fr_s5.e     <= e_s4;
			fr_s5.reach <= reach_s4;
		end
	end

	// square-root chain, one result bit per cell
	sq_t sq [SQRT_STEPS+1];
	fr_t fd_q [SQRT_STEPS];

	assign sq[0].rem  = v_s5;
	assign sq[0].root = '0;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		tlik_sqrt_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.en     (en),
			.din    (sq[i]),
			.dout_q (sq[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fd_q[0] <= fr_s5;
			for (int i = 1; i < SQRT_STEPS; i++) begin
				fd_q[i] <= fd_q[i-1];
			end
		end
	end

	// stage 6: CORDIC operands
	fr_t                fa;
	logic [31:0]        s_w;
	logic [46:0]        a2s_s6;
	logic signed [49:0] e_s6;
	logic               reach_s6, num_neg_s6;
	logic [1:0]         t_code_s6;
	logic [47:0]        tx_s6, kx_s6;
	logic signed [48:0] ty_s6, ky_s6;
	logic signed [48:0] yw, xw, numw, sw;

	assign fa   = fd_q[SQRT_STEPS-1];
	assign s_w  = sq[SQRT_STEPS].root[31:0];
	assign yw   = 49'(fa.y);
	assign xw   = 49'(fa.x);
	assign numw = 49'(fa.num);
	assign sw   = $signed({17'b0, s_w});

	always_ff @(posedge clk) begin
		if (en) begin
			a2s_s6     <= 47'(fa.a2) * 47'(s_w);
			e_s6       <= fa.e;
			reach_s6   <= fa.reach;
			num_neg_s6 <= fa.num[32];
			if (fa.x != '0) t_code_s6 <= RAT_CORDIC;
			else if (fa.y > 0) t_code_s6 <= RAT_POS;
			else if (fa.y < 0) t_code_s6 <= RAT_NEG;
			else t_code_s6 <= RAT_ZERO;
			tx_s6 <= fa.x[15] ? 48'(-xw) : 48'(xw);
			ty_s6 <= fa.x[15] ? -yw : yw;
			if (fa.num[32]) begin
				kx_s6 <= 48'(s_w);
				ky_s6 <= -numw;
			end else begin
				kx_s6 <= 48'(numw);
				ky_s6 <= sw;
			end
		end
	end

	// shoulder correction term: atan(a2*s / e)
	logic [47:0]        fx_w;
	logic signed [48:0] fy_w, a2sw;
	logic signed [49:0] eneg_w;
	logic [1:0]         k_code_w;

	assign a2sw     = $signed({2'b0, a2s_s6});
	assign eneg_w   = -e_s6;
	assign fx_w     = e_s6[49] ? eneg_w[47:0] : e_s6[47:0];
	assign fy_w     = e_s6[49] ? -a2sw : a2sw;
	assign k_code_w = (e_s6 != '0) ? RAT_CORDIC :
		((a2s_s6 != '0) ? RAT_POS : RAT_ZERO);

	logic signed [ZW-1:0] zt, zk, zf;

	tlik_cordic #(.NSTEPS(NSTEPS)) u_cor_tgt (
		.clk   (clk),
		.en    (en),
		.x_in  (tx_s6),
		.y_in  (ty_s6),
		.z_out (zt)
	);

	tlik_cordic #(.NSTEPS(NSTEPS)) u_cor_elb (
		.clk   (clk),
		.en    (en),
		.x_in  (kx_s6),
		.y_in  (ky_s6),
		.z_out (zk)
	);

	tlik_cordic #(.NSTEPS(NSTEPS)) u_cor_fk (
		.clk   (clk),
		.en    (en),
		.x_in  (fx_w),
		.y_in  (fy_w),
		.z_out (zf)
	);

	side_t cd_q [CL];

	always_ff @(posedge clk) begin
		if (en) begin
			cd_q[0].reach   <= reach_s6;
			cd_q[0].num_neg <= num_neg_s6;
			cd_q[0].t_code  <= t_code_s6;
			cd_q[0].k_code  <= k_code_w;
			for (int i = 1; i < CL; i++) begin
				cd_q[i] <= cd_q[i-1];
			end
		end
	end

	// final stages: combine angles, wrap shoulder, round to Q2.13
	side_t              sd;
	logic signed [35:0] q1_f1, q2_f1;
	logic               reach_f1;
	logic signed [35:0] q1_w;
	res_t               res_q;

	assign sd = cd_q[CL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			reach_f1 <= sd.reach;
			q1_f1    <= rat_val(sd.t_code, zt) - rat_val(sd.k_code, zf);
			q2_f1    <= sd.num_neg ? HALF_PI_Q30 + 36'(zk) : 36'(zk);
		end
	end

	assign q1_w = q1_f1[35] ? q1_f1 + PI_Q30 : q1_f1;

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.reachable      <= reach_f1;
			res_q.shoulder_angle <= reach_f1 ? to_q13(q1_w) : '0;
			res_q.elbow_angle    <= reach_f1 ? to_q13(q2_f1) : '0;
		end
	end

	assign res.data = res_q;
endmodule
`default_nettype wire

// ===== rtl/core/tlik_sqrt_cell.sv =====
`default_nettype none
module tlik_sqrt_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          en,
	input  tlik_pkg::sq_t din,
	output tlik_pkg::sq_t dout_q
);
	import tlik_pkg::*;

	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

	logic [63:0] trial;
	assign trial = din.root + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (din.rem >= trial) begin
				dout_q.rem  <= din.rem - trial;
				dout_q.root <= (din.root >> 1) + BIT;
			end else begin
				dout_q.rem  <= din.rem;
				dout_q.root <= din.root >> 1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/tlik_norm_cell.sv =====
`default_nettype none
module tlik_norm_cell #(
	parameter int SHIFT = 1
) (
	input  logic           clk,
	input  logic           en,
	input  tlik_pkg::nrm_t din,
	output tlik_pkg::nrm_t dout_q
);
	import tlik_pkg::*;

	localparam int TOP = 47 - SHIFT;

	logic room;
	// shift only while the larger magnitude stays below bit 47
	assign room = ((din.x | din.my) >> TOP) == '0;

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q.neg  <= din.neg;
			dout_q.zero <= din.zero;
			if (room) begin
				dout_q.x  <= din.x << SHIFT;
				dout_q.my <= din.my << SHIFT;
			end else begin
				dout_q.x  <= din.x;
				dout_q.my <= din.my;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/tlik_iter_cell.sv =====
`default_nettype none
module tlik_iter_cell #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           en,
	input  tlik_pkg::cor_t din,
	output tlik_pkg::cor_t dout_q
);
	import tlik_pkg::*;

	localparam logic signed [ZW-1:0] ATAN = $signed(atan_lut(5'(IDX)));

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	assign dx = $signed(din.y) >>> IDX;
	assign dy = $signed(din.x) >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q.zero <= din.zero;
			if (!din.y[CW-1]) begin
				dout_q.x <= din.x + dx;
				dout_q.y <= din.y - dy;
				dout_q.z <= din.z + ATAN;
			end else begin
				dout_q.x <= din.x - dx;
				dout_q.y <= din.y + dy;
				dout_q.z <= din.z - ATAN;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/tlik_cordic.sv =====
`default_nettype none
module tlik_cordic #(
	parameter int NSTEPS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [47:0]                   x_in,
	input  logic signed [48:0]            y_in,
	output logic signed [tlik_pkg::ZW-1:0] z_out
);
	import tlik_pkg::*;

	nrm_t              nrm [NORM_CELLS+1];
	cor_t              cor [NSTEPS+1];
	logic signed [48:0] ymag;

	assign ymag = y_in[48] ? -y_in : y_in;

	always_ff @(posedge clk) begin
		if (en) begin
			nrm[0].x    <= x_in;
			nrm[0].my   <= ymag[47:0];
			nrm[0].neg  <= y_in[48];
			nrm[0].zero <= (x_in == '0) && (ymag == '0);
		end
	end

	// shifts of 32, 16, 8, 4, 2, 1 bring the larger magnitude to bit 46
	for (genvar k = 0; k < NORM_CELLS; k++) begin : g_norm
		tlik_norm_cell #(.SHIFT(32 >> k)) u_cell (
			.clk    (clk),
			.en     (en),
			.din    (nrm[k]),
			.dout_q (nrm[k+1])
		);
	end

	assign cor[0].x    = $signed({(CW-48)'(0), nrm[NORM_CELLS].x});
	assign cor[0].y    = nrm[NORM_CELLS].neg ?
		-$signed({(CW-48)'(0), nrm[NORM_CELLS].my}) :
		$signed({(CW-48)'(0), nrm[NORM_CELLS].my});
	assign cor[0].z    = '0;
	assign cor[0].zero = nrm[NORM_CELLS].zero;

	for (genvar i = 0; i < NSTEPS; i++) begin : g_iter
		tlik_iter_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.en     (en),
			.din    (cor[i]),
			.dout_q (cor[i+1])
		);
	end

	assign z_out = cor[NSTEPS].zero ? '0 : cor[NSTEPS].z;
endmodule
`default_nettype wire

// ===== tb/tlik_checker.sv =====
`timescale 1ns / 1ps
module tlik_checker #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_ready,
	input  tlik_pkg::cmd_t cmd_data,
	input  logic          res_valid,
	input  logic          res_ready,
	input  tlik_pkg::res_t res_data,
	output int            errors,
	output int            pending
);
	import tlik_pkg::*;

	localparam longint PI_FIX      = 64'sd3373259426;
	localparam longint HALF_PI_FIX = 64'sd1686629713;
	localparam longint PI_OUT      = 64'sd25736;

	res_t angles_due[$];

	function automatic longint atan_step(input int i);
		longint t[32];
		t = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
			64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
			64'h00000001, 64'h00000000};
		return t[i];
	endfunction

	function automatic longint floor_root(input longint unsigned v);
		longint unsigned rem, root, b;
		rem = v;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return longint'(root);
	endfunction

	// vectoring rotation, x >= 0; result in Q2.30
	function automatic longint vector_angle(input longint x, input longint y);
		bit     neg;
		longint my, z, dx, dy;
		neg = y < 0;
		my = neg ? -y : y;
		z = 0;
		if (x == 0 && my == 0) return 0;
		while (x < (64'sd1 <<< 46) && my < (64'sd1 <<< 46)) begin
			x = x * 2;
			my = my * 2;
		end
		y = neg ? -my : my;
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += atan_step(i);
			end else begin
				x -= dx;
				y += dy;
				z -= atan_step(i);
			end
		end
		return z;
	endfunction

	function automatic longint ratio_angle(input longint n, input longint d);
		if (d == 0) return n > 0 ? HALF_PI_FIX : (n < 0 ? -HALF_PI_FIX : 0);
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		return vector_angle(d, n);
	endfunction

	function automatic logic [14:0] round_out(input longint z);
		longint q;
		if (z < 0) z = 0;
		if (z > PI_FIX) z = PI_FIX;
		q = (z + 65536) >>> 17;
		if (q > PI_OUT) q = PI_OUT;
		return q[14:0];
	endfunction

	function automatic res_t joint_angles(input cmd_t c);
		res_t   r;
		longint x, y, a1, a2, r2, sum, dif, num, den, s, q1, q2;
		x = c.target_x;
		y = c.target_y;
		a1 = c.inner_length;
		a2 = c.outer_length;
		r2 = x * x + y * y;
		sum = a1 + a2;
		dif = a1 - a2;
		r = '0;
		if (a1 == 0 || a2 == 0 || r2 > sum * sum || r2 < dif * dif) return r;
		den = 2 * a1 * a2;
		num = r2 - a1 * a1 - a2 * a2;
		s = floor_root(longint'(unsigned'(den - num) * unsigned'(den + num)));
		if (num >= 0) q2 = vector_angle(num, s);
		else q2 = HALF_PI_FIX + vector_angle(s, -num);
		q1 = ratio_angle(y, x) - ratio_angle(a2 * s, a1 * den + a2 * num);
		if (q1 < 0) q1 += PI_FIX;
		r.reachable = 1'b1;
		r.shoulder_angle = round_out(q1);
		r.elbow_angle = round_out(q2);
		return r;
	endfunction

	assign pending = angles_due.size();

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		int   bad;
		bad = 0;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (cmd_valid && cmd_ready) angles_due.push_back(joint_angles(cmd_data));
			if (res_valid && res_ready) begin
				if (angles_due.size() == 0) begin
					$error("result beat with nothing expected");
					bad++;
				end else begin
					want = angles_due.pop_front();
					if (res_data.reachable !== want.reachable) begin
						$error("reachable: expected %0d got %0d", want.reachable,
							res_data.reachable);
						bad++;
					end
					if (res_data.shoulder_angle !== want.shoulder_angle) begin
						$error("shoulder_angle: expected %0d got %0d",
							want.shoulder_angle, res_data.shoulder_angle);
						bad++;
					end
					if (res_data.elbow_angle !== want.elbow_angle) begin
						$error("elbow_angle: expected %0d got %0d", want.elbow_angle,
							res_data.elbow_angle);
						bad++;
					end
				end
			end
			errors <= errors + bad;
		end
	end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import tlik_pkg::*;

	localparam int STEPS = 16;
	localparam int LATENCY = 47 + STEPS;
	localparam int N_RANDOM = 850;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, pending, cycles, sent, total;
	int   src_gap, snk_gap;
	bit   calm;
	cmd_t plan[$];

	tlik_stream_if #(.T(cmd_t)) cmd ();
	tlik_stream_if #(.T(res_t)) res ();

	two_link_inverse_kinematics_top #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .res(res.source)
	);

	tlik_checker #(.CORDIC_STEPS(STEPS)) chk (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd.valid), .cmd_ready(cmd.ready), .cmd_data(cmd.data),
		.res_valid(res.valid), .res_ready(res.ready), .res_data(res.data),
		.errors(errors), .pending(pending)
	);

	always #1 clk = ~clk;

	function automatic cmd_t make_cmd(input int x, input int y, input int a1, input int a2);
		cmd_t c;
		c.target_x = x[15:0];
		c.target_y = y[15:0];
		c.inner_length = a1[14:0];
		c.outer_length = a2[14:0];
		return c;
	endfunction

	// mostly targets inside the annulus so that the angle paths get exercised
	function automatic cmd_t random_cmd();
		int   a1, a2, x, y, r, k;
		cmd_t c;
		k = $urandom_range(0, 9);
		if (k < 2) begin
			c.target_x = 16'($urandom());
			c.target_y = 16'($urandom());
			c.inner_length = 15'($urandom());
			c.outer_length = 15'($urandom());
			return c;
		end
		a1 = (k < 4) ? $urandom_range(1, 32767) : $urandom_range(1, 15000);
		a2 = (k < 4) ? $urandom_range(1, 32767) : $urandom_range(1, 15000);
		r = $urandom_range(0, 23000);
		x = $urandom_range(0, r);
		y = $urandom_range(0, 23000);
		if (y * 0 == 0 && x * x > 0) y = $urandom_range(0, 23000);
		if ($urandom_range(0, 1)) x = -x;
		if ($urandom_range(0, 1)) y = -y;
		if (k == 9) begin
			x = x / 64;
			y = y / 64;
		end
		return make_cmd(x, y, a1, a2);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.data <= '0;
			res.ready <= 1'b0;
			sent <= 0;
			src_gap <= 0;
			snk_gap <= 0;
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
			if (!cmd.valid || cmd.ready) begin
				if (cmd.valid) sent <= sent + 1;
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					cmd.valid <= 1'b0;
				end else if (sent + (cmd.valid ? 1 : 0) < plan.size()) begin
					cmd.valid <= 1'b1;
					cmd.data <= plan[sent + (cmd.valid ? 1 : 0)];
					if (!calm && $urandom_range(0, 15) == 0)
						src_gap <= $urandom_range(1, 10);
				end else begin
					cmd.valid <= 1'b0;
				end
			end
			if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
				if (!calm && $urandom_range(0, 15) == 0) snk_gap <= $urandom_range(1, 10);
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		calm = 1'b0;
		plan.push_back(make_cmd(0, 0, 100, 100));
		plan.push_back(make_cmd(200, 0, 100, 100));
		plan.push_back(make_cmd(0, 200, 100, 100));
		plan.push_back(make_cmd(-200, 0, 100, 100));
		plan.push_back(make_cmd(0, -200, 100, 100));
		plan.push_back(make_cmd(201, 0, 100, 100));
		plan.push_back(make_cmd(50, 0, 150, 100));
		plan.push_back(make_cmd(49, 0, 150, 100));
		plan.push_back(make_cmd(100, 100, 0, 100));
		plan.push_back(make_cmd(100, 100, 100, 0));
		plan.push_back(make_cmd(-32768, -32768, 32767, 32767));
		plan.push_back(make_cmd(32767, 32767, 32767, 32767));
		plan.push_back(make_cmd(32767, -32768, 32767, 32767));
		plan.push_back(make_cmd(-32768, 0, 32767, 1));
		plan.push_back(make_cmd(0, 32767, 1, 32767));
		plan.push_back(make_cmd(1, 0, 1, 1));
		plan.push_back(make_cmd(-1, -1, 1, 1));
		plan.push_back(make_cmd(141, 141, 100, 100));
		plan.push_back(make_cmd(-100, 100, 100, 50));
		plan.push_back(make_cmd(30, -40, 25, 25));
		plan.push_back(make_cmd(0, 0, 32767, 32767));
		plan.push_back(make_cmd(-1, 0, 16384, 16383));
		for (int i = 0; i < N_RANDOM; i++) plan.push_back(random_cmd());
		total = plan.size();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (sent >= total - 150);
		calm = 1'b1;
		wait (sent == total);
		wait (pending == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
